### hdl/rrt_pkg.sv
// Shared types and constants for the row rank transform.
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

    // Field widths of the sample and result items
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 16;
    localparam int RANK_W         = 6;
    localparam int SAMPLE_MAX_DEF = 64;

    // Sample travelling down the chain, carrying its running rank
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic [RANK_W-1:0]         cnt;
    } mv_t;

    // Sample settled in a cell
    typedef struct packed {
        logic                      occ;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic [RANK_W-1:0]         rank;
    } slot_t;

    // Chain-wide control from the sequencer
    typedef struct packed {
        logic shift;
    } ctrl_t;

endpackage
`default_nettype wire

### hdl/rrt_if.sv
// Handshake channels for sample items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface rrt_in_if;
    import rrt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      last;

    modport source (output valid, value, position, last, input ready);
    modport sink (input valid, value, position, last, output ready);
endinterface

interface rrt_out_if;
    import rrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position_res;
    logic [RANK_W-1:0] rank;
    logic              overflow;
    logic              last_res;

    modport source (output valid, position_res, rank, overflow, last_res, input ready);
    modport sink (input valid, position_res, rank, overflow, last_res, output ready);
endinterface
`default_nettype wire

### hdl/row_rank_transform.sv
// Top level: loads a row of samples into a compare-cell chain and emits ordinal ranks.
// Each sample walks the cell chain one cell per cycle until it settles in the first free cell.
// Throughput: one item per cycle while loading, then a drain until no sample is moving, then
// one result per cycle while the receiver is ready.
// Reset: asynchronous, active low; empties the chain, clears counters and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module row_rank_transform #(
    parameter int SAMPLE_MAX = rrt_pkg::SAMPLE_MAX_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    rrt_in_if.sink     samples,
    rrt_out_if.source  results
);
    import rrt_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_MAX + 1);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               overflow_reg, overflow_next;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               accept;
    logic               store;
    logic               out_load;
    logic               emit_final;
    ctrl_t              ctrl;

    mv_t                mv_chain   [0:SAMPLE_MAX-1];
    slot_t              slot_chain [0:SAMPLE_MAX];
    mv_t                mv_tail;
    logic [SAMPLE_MAX-1:0] busy_vec;
    logic [SAMPLE_MAX-1:0] occ_vec;

    // Input handshake
    assign samples.ready = (state_reg == ST_LOAD);
    assign accept        = samples.valid && samples.ready;
    assign store         = accept && (count_reg < CNT_W'(SAMPLE_MAX));

    // Chain entry
    always_comb
    begin
        mv_chain[0].valid    = store;
        mv_chain[0].value    = samples.value;
        mv_chain[0].position = samples.position;
        mv_chain[0].cnt      = '0;
    end

    assign slot_chain[SAMPLE_MAX] = '0;
    assign ctrl.shift = out_load;

    // Row of compare cells
    genvar gi;
    generate
        for (gi = 0; gi < SAMPLE_MAX; gi++)
        begin : g_cell
            mv_t mv_nb;

            rrt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .mv_in    (mv_chain[gi]),
                .mv_out   (mv_nb),
                .slot_in  (slot_chain[gi+1]),
                .slot_out (slot_chain[gi]),
                .busy     (busy_vec[gi])
            );

            assign occ_vec[gi] = slot_chain[gi].occ;

            if (gi < SAMPLE_MAX - 1)
            begin : g_link
                assign mv_chain[gi+1] = mv_nb;
            end
            else
            begin : g_tail
                assign mv_tail = mv_nb;
            end
        end
    endgenerate

    // Result emission from the head cell
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready)
                        && (emit_idx_reg != count_reg);
    assign emit_final = out_load && (emit_idx_reg == count_reg - CNT_W'(1));

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (store)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (accept)
                begin
                    overflow_next = 1'b1;
                end
                if (accept && samples.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (busy_vec == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_final)
                begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    emit_idx_next = '0;
                    overflow_next = 1'b0;
                end
                else if (out_load)
                begin
                    emit_idx_next = emit_idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pos_reg  <= slot_chain[0].position;
            out_rank_reg <= slot_chain[0].rank;
            out_ovf_reg  <= overflow_reg;
            out_last_reg <= (emit_idx_reg == count_reg - CNT_W'(1));
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.position_res = out_pos_reg;
    assign results.rank         = out_rank_reg;
    assign results.overflow     = out_ovf_reg;
    assign results.last_res     = out_last_reg;

    // Checks
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |->
        ($countones(occ_vec) + $countones(busy_vec) == int'(count_reg)))
        else $error("loaded count disagrees with chain occupancy");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
        ($countones(occ_vec) == int'(count_reg) - int'(emit_idx_reg)))
        else $error("chain occupancy disagrees with emitted count");

    a_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (busy_vec == '0))
        else $error("sample still moving while emitting");

    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + SAMPLE_MAX'(1)) & occ_vec) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !mv_tail.valid)
        else $error("sample walked past the end of the chain");

endmodule
`default_nettype wire

### hdl/rrt_cell.sv
// One compare cell: holds a settled sample and ranks it against samples passing by.
`timescale 1ns / 1ps
`default_nettype none
module rrt_cell (
    input  wire            clk,
    input  wire            rst_n,
    input  rrt_pkg::ctrl_t ctrl,
    input  rrt_pkg::mv_t   mv_in,
    output rrt_pkg::mv_t   mv_out,
    input  rrt_pkg::slot_t slot_in,
    output rrt_pkg::slot_t slot_out,
    output logic           busy
);
    import rrt_pkg::*;

    mv_t   mv_reg;
    slot_t slot_reg;
    slot_t slot_next;
    logic  hit;
    logic  le;

    // Compare the passing sample with the settled one
    assign hit = mv_reg.valid && slot_reg.occ;
    assign le  = slot_reg.value <= mv_reg.value;

    // Hand the passing sample on; count settled samples that rank below it
    always_comb
    begin
        mv_out          = mv_reg;
        mv_out.valid    = hit;
        mv_out.cnt      = le ? mv_reg.cnt + RANK_W'(1) : mv_reg.cnt;
    end

    // Settle, bump rank when a later smaller sample passes, or shift out
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.shift)
        begin
            slot_next = slot_in;
        end
        else if (mv_reg.valid && !slot_reg.occ)
        begin
            slot_next.occ      = 1'b1;
            slot_next.value    = mv_reg.value;
            slot_next.position = mv_reg.position;
            slot_next.rank     = mv_reg.cnt;
        end
        else if (hit && !le)
        begin
            slot_next.rank = slot_reg.rank + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= '0;
            slot_reg <= '0;
        end
        else
        begin
            mv_reg   <= mv_in;
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;
    assign busy     = mv_reg.valid;

endmodule
`default_nettype wire
